// ----- hdl/mbd_pkg.sv -----
// Shared types and constants of the mipmap box downsampler.
// Used by the top level, the front end and the back end; depends on nothing.
`timescale 1ns / 1ps

package mbd_pkg;

    localparam int CHAN_W  = 24;
    localparam int PAIR_W  = CHAN_W + 1;
    localparam int SUM_W   = CHAN_W + 2;
    localparam int CFG_W   = 4;
    localparam int IDX_W   = 2;
    localparam int ROW_W   = 12;
    localparam int HEIGHT_LOG2_MAX = 12;

    localparam logic [IDX_W-1:0] REG_WIDTH_LOG2  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT_LOG2 = 2'd1;
    localparam logic [IDX_W-1:0] REG_WRAP_MODE   = 2'd2;

    localparam logic [1:0] WRAP_BLACK = 2'd2;

    typedef enum logic [1:0] {
        HOP_LEFT   = 2'd0,
        HOP_RIGHT  = 2'd1,
        HOP_SINGLE = 2'd2
    } hop_t;

    typedef enum logic [1:0] {
        VOP_STORE   = 2'd0,
        VOP_COMBINE = 2'd1,
        VOP_SINGLE  = 2'd2
    } vop_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        hop_t hop;
        vop_t vop;
        logic black;
        logic last;
    } item_ctrl_t;

endpackage

// ----- hdl/mipmap_box_downsample.sv -----
// Top level of the mipmap box downsampler: front end, item queue, back end.
// Depends on mbd_pkg, mbd_front, mbd_queue and mbd_back.
`timescale 1ns / 1ps

// The block takes one source pixel per cycle in raster order while the queue
// has room, and returns one averaged pixel per completed 2x2 block (smaller
// on a level one texel wide or high), with end_of_level set on its last block.
// An item passes the front end in the cycle it is accepted, waits in a
// two-entry queue, then passes the line buffer read and output registers.
// The line buffer holds MAX_WIDTH/2 pair sums, read once and written at most
// once per item; the back end takes one item per cycle unless the output
// stalls. Writing any register restarts the level at its top left pixel.

module mipmap_box_downsample import mbd_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAN_W-1:0] s_red_in,
    input  logic [CHAN_W-1:0] s_green_in,
    input  logic [CHAN_W-1:0] s_blue_in,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAN_W-1:0] m_red_out,
    output logic [CHAN_W-1:0] m_green_out,
    output logic [CHAN_W-1:0] m_blue_out,
    output logic              m_end_of_level
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int Q_W        = SLOT_W + $bits(pixel_t) + $bits(item_ctrl_t);

    logic              q_full;
    logic              q_push;
    pixel_t            fe_pixel;
    item_ctrl_t        fe_ctrl;
    logic [SLOT_W-1:0] fe_slot;
    logic              q_valid;
    logic              q_pop;
    logic [Q_W-1:0]    q_rd_data;
    pixel_t            be_pixel;
    item_ctrl_t        be_ctrl;
    logic [SLOT_W-1:0] be_slot;

    mbd_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_red_in    (s_red_in),
        .s_green_in  (s_green_in),
        .s_blue_in   (s_blue_in),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_pixel     (fe_pixel),
        .q_ctrl      (fe_ctrl),
        .q_slot      (fe_slot)
    );

    mbd_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_push),
        .wr_data  ({fe_slot, fe_pixel, fe_ctrl}),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_rd_data)
    );

    assign {be_slot, be_pixel, be_ctrl} = q_rd_data;

    mbd_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_pixel        (be_pixel),
        .q_ctrl         (be_ctrl),
        .q_slot         (be_slot),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red_out      (m_red_out),
        .m_green_out    (m_green_out),
        .m_blue_out     (m_blue_out),
        .m_end_of_level (m_end_of_level)
    );

endmodule

// ----- hdl/mbd_front.sv -----
// Front end of the mipmap box downsampler: configuration registers, raster
// counters and classification of each accepted item. Depends on mbd_pkg.
`timescale 1ns / 1ps

module mbd_front import mbd_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [IDX_W-1:0]            cfg_index,
    input  logic [CFG_W-1:0]            cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [CHAN_W-1:0]           s_red_in,
    input  logic [CHAN_W-1:0]           s_green_in,
    input  logic [CHAN_W-1:0]           s_blue_in,
    input  logic                        q_full,
    output logic                        q_push,
    output pixel_t                      q_pixel,
    output item_ctrl_t                  q_ctrl,
    output logic [((MAX_WIDTH/2 > 1) ? $clog2(MAX_WIDTH/2) : 1)-1:0] q_slot
);

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic [CFG_W-1:0] width_log2_reg;
    logic [CFG_W-1:0] height_log2_reg;
    logic [1:0]       wrap_mode_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [CFG_W-1:0] wl_eff;
    logic [CFG_W-1:0] hl_eff;
    logic [COL_W:0]   col_span;
    logic [COL_W-1:0] col_mask;
    logic [ROW_W:0]   row_span;
    logic [ROW_W-1:0] row_mask;
    logic [COL_W-1:0] col_half;
    logic             last_col;
    logic             last_row;
    logic             cfg_hit;

    assign wl_eff = (int'(width_log2_reg) > COL_W) ? CFG_W'(COL_W) : width_log2_reg;
    assign hl_eff = (int'(height_log2_reg) > HEIGHT_LOG2_MAX) ?
                    CFG_W'(HEIGHT_LOG2_MAX) : height_log2_reg;

    assign col_span = (COL_W+1)'(1) << wl_eff;
    assign col_mask = COL_W'(col_span - 1'b1);
    assign row_span = (ROW_W+1)'(1) << hl_eff;
    assign row_mask = ROW_W'(row_span - 1'b1);

    assign last_col = (col_reg == col_mask);
    assign last_row = (row_reg == row_mask);
    assign col_half = col_reg >> 1;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    assign q_pixel.red   = s_red_in;
    assign q_pixel.green = s_green_in;
    assign q_pixel.blue  = s_blue_in;

    always_comb begin
        if (wl_eff == '0) begin
            q_ctrl.hop = HOP_SINGLE;
        end else if (col_reg[0]) begin
            q_ctrl.hop = HOP_RIGHT;
        end else begin
            q_ctrl.hop = HOP_LEFT;
        end
        if (hl_eff == '0) begin
            q_ctrl.vop = VOP_SINGLE;
        end else if (row_reg[0]) begin
            q_ctrl.vop = VOP_COMBINE;
        end else begin
            q_ctrl.vop = VOP_STORE;
        end
        q_ctrl.black = (wrap_mode_reg == WRAP_BLACK);
        q_ctrl.last  = last_col && last_row;
        q_slot = (int'(col_half) >= LINE_DEPTH) ? '0 : SLOT_W'(col_half);
    end

    assign cfg_hit = cfg_wr_en && (cfg_index == REG_WIDTH_LOG2 ||
                     cfg_index == REG_HEIGHT_LOG2 || cfg_index == REG_WRAP_MODE);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit) begin
            col_next = '0;
            row_next = '0;
        end else if (q_push) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_log2_reg  <= '0;
            height_log2_reg <= '0;
            wrap_mode_reg   <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_WIDTH_LOG2:  width_log2_reg  <= cfg_wr_data;
                    REG_HEIGHT_LOG2: height_log2_reg <= cfg_wr_data;
                    REG_WRAP_MODE:   wrap_mode_reg   <= cfg_wr_data[1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- hdl/mbd_queue.sv -----
// Two-entry item queue between the front end and the back end.
// Depends on nothing but its data width.
`timescale 1ns / 1ps

module mbd_queue #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_data,
    output logic              full,
    input  logic              rd_en,
    output logic              rd_valid,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] store_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg, count_next;
    logic              push;
    logic              pop;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = store_reg[rd_ptr_reg];
    assign push     = wr_en && !full;
    assign pop      = rd_en && rd_valid;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("item queue count out of range");

    a_count_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("item queue lost a pushed item");
`endif

endmodule

// ----- hdl/mbd_back.sv -----
// Back end of the mipmap box downsampler: pair register, line buffer,
// block sums and the output register. Depends on mbd_pkg.
`timescale 1ns / 1ps

module mbd_back import mbd_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    output logic                        q_pop,
    input  pixel_t                      q_pixel,
    input  item_ctrl_t                  q_ctrl,
    input  logic [((MAX_WIDTH/2 > 1) ? $clog2(MAX_WIDTH/2) : 1)-1:0] q_slot,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [CHAN_W-1:0]           m_red_out,
    output logic [CHAN_W-1:0]           m_green_out,
    output logic [CHAN_W-1:0]           m_blue_out,
    output logic                        m_end_of_level
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;

    logic [2:0][PAIR_W-1:0] line_mem [LINE_DEPTH];
    logic [2:0][PAIR_W-1:0] line_rd_reg;
    logic [2:0][CHAN_W-1:0] pair_reg;
    logic [2:0][PAIR_W-1:0] s1_hs_reg;
    logic                   s1_valid_reg;
    logic                   s1_use_line_reg;
    logic                   s1_dup_reg;
    logic                   s1_last_reg;
    logic                   m_valid_reg;
    logic [2:0][CHAN_W-1:0] m_chan_reg;
    logic                   m_last_reg;

    logic [2:0][CHAN_W-1:0] pix;
    logic [2:0][PAIR_W-1:0] hs;
    logic [2:0][SUM_W-1:0]  vs;
    logic                   adv_out;
    logic                   load1;
    logic                   block_done;

    assign pix[0] = q_pixel.red;
    assign pix[1] = q_pixel.green;
    assign pix[2] = q_pixel.blue;

    assign adv_out    = !m_valid_reg || m_ready;
    assign load1      = !s1_valid_reg || adv_out;
    assign q_pop      = q_valid && load1;
    assign block_done = (q_ctrl.hop != HOP_LEFT) && (q_ctrl.vop != VOP_STORE);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            case (q_ctrl.hop)
                HOP_RIGHT:  hs[k] = PAIR_W'(pair_reg[k]) + PAIR_W'(pix[k]);
                HOP_SINGLE: hs[k] = PAIR_W'(pix[k]) +
                                    (q_ctrl.black ? '0 : PAIR_W'(pix[k]));
                default:    hs[k] = PAIR_W'(pix[k]);
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (s1_use_line_reg) begin
                vs[k] = SUM_W'(s1_hs_reg[k]) + SUM_W'(line_rd_reg[k]);
            end else if (s1_dup_reg) begin
                vs[k] = SUM_W'(s1_hs_reg[k]) + SUM_W'(s1_hs_reg[k]);
            end else begin
                vs[k] = SUM_W'(s1_hs_reg[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (load1) begin
                s1_valid_reg <= q_pop && block_done;
            end
            if (adv_out) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            if (q_ctrl.hop == HOP_LEFT) begin
                pair_reg <= pix;
            end
            s1_hs_reg       <= hs;
            s1_use_line_reg <= (q_ctrl.vop == VOP_COMBINE);
            s1_dup_reg      <= (q_ctrl.vop == VOP_SINGLE) && !q_ctrl.black;
            s1_last_reg     <= q_ctrl.last;
            line_rd_reg     <= line_mem[q_slot];
            if (q_ctrl.hop != HOP_LEFT && q_ctrl.vop == VOP_STORE) begin
                line_mem[q_slot] <= hs;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_out && s1_valid_reg) begin
            for (int k = 0; k < 3; k++) begin
                m_chan_reg[k] <= vs[k][SUM_W-1:2];
            end
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_red_out      = m_chan_reg[0];
    assign m_green_out    = m_chan_reg[1];
    assign m_blue_out     = m_chan_reg[2];
    assign m_end_of_level = m_last_reg;

`ifndef ASSERT_OFF
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !adv_out) |=> s1_valid_reg)
        else $error("pending block sum dropped while output stalled");

    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_valid_reg))
        else $error("result item appeared without a block sum");
`endif

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the mipmap box downsampler: directed items, random levels under
// changing back-pressure and oversized sizes, checked against a predictor of the 2x2 average.
// Depends on mbd_pkg and mipmap_box_downsample.

module tb;
    import mbd_pkg::*;

    localparam int MAX_WIDTH      = 4096;
    localparam int WIDTH_LOG2_MAX = 12;
    localparam int LINE_SLOTS     = MAX_WIDTH / 2;
    localparam int SETTLE_CYCLES  = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int STALL_LIMIT    = 2000;
    localparam int REGIME_ITEMS   = 400;
    localparam int OVERSIZE_ITEMS = 260;
    localparam int REPORT_LIMIT   = 10;

    localparam logic [IDX_W-1:0] REG_UNUSED  = 2'd3;
    localparam logic [CFG_W-1:0] WRAP_REPEAT = 4'd0;
    localparam logic [CFG_W-1:0] WRAP_CLAMP  = 4'd1;
    localparam logic [CFG_W-1:0] WRAP_ZERO   = 4'd2;
    localparam logic [CFG_W-1:0] WRAP_SPARE  = 4'd3;

    localparam pixel_t PIXEL_FULL = '1;
    localparam pixel_t PIXEL_ZERO = '0;

    typedef struct packed {
        pixel_t px;
        logic   last;
    } block_result_t;

    class box_filter_scoreboard;
        logic [CFG_W-1:0]  width_log2;
        logic [CFG_W-1:0]  height_log2;
        logic [1:0]        wrap_mode;
        int unsigned       column;
        int unsigned       row;
        logic [PAIR_W-1:0] pair_sum [3];
        logic [PAIR_W-1:0] line_sum [3][LINE_SLOTS];
        block_result_t     expected_q[$];
        int unsigned       failures;

        function new();
            width_log2  = '0;
            height_log2 = '0;
            wrap_mode   = '0;
            column      = 0;
            row         = 0;
            failures    = 0;
            foreach (pair_sum[k]) pair_sum[k] = '0;
            foreach (line_sum[k, s]) line_sum[k][s] = '0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void set_register(logic [IDX_W-1:0] index, logic [CFG_W-1:0] value);
            case (index)
                REG_WIDTH_LOG2:  width_log2 = value;
                REG_HEIGHT_LOG2: height_log2 = value;
                REG_WRAP_MODE:   wrap_mode = value[1:0];
                default:         return;
            endcase
            column = 0;
            row    = 0;
        endfunction

        function void note_input(pixel_t px);
            logic [CHAN_W-1:0] texel [3];
            logic [PAIR_W-1:0] across [3];
            logic [SUM_W-1:0]  block [3];
            int unsigned       w;
            int unsigned       h;
            int unsigned       slot;
            hop_t              hop;
            vop_t              vop;
            logic              black;
            logic              last;
            block_result_t     res;
            texel[0] = px.red;
            texel[1] = px.green;
            texel[2] = px.blue;
            w = (width_log2 >= WIDTH_LOG2_MAX) ? MAX_WIDTH : (1 << width_log2);
            h = 1 << ((height_log2 > HEIGHT_LOG2_MAX) ? HEIGHT_LOG2_MAX : height_log2);
            black = (wrap_mode == WRAP_BLACK);
            slot = column >> 1;
            hop = (w == 1) ? HOP_SINGLE : ((column % 2) != 0) ? HOP_RIGHT : HOP_LEFT;
            vop = (h == 1) ? VOP_SINGLE : ((row % 2) != 0) ? VOP_COMBINE : VOP_STORE;
            last = (column == w - 1) && (row == h - 1);
            for (int k = 0; k < 3; k++) begin
                case (hop)
                    HOP_SINGLE: across[k] = PAIR_W'(texel[k]) + (black ? '0 : PAIR_W'(texel[k]));
                    HOP_RIGHT:  across[k] = pair_sum[k] + PAIR_W'(texel[k]);
                    default:    pair_sum[k] = PAIR_W'(texel[k]);
                endcase
                if (hop != HOP_LEFT) begin
                    case (vop)
                        VOP_SINGLE:  block[k] = SUM_W'(across[k]) +
                                                (black ? '0 : SUM_W'(across[k]));
                        VOP_COMBINE: block[k] = SUM_W'(line_sum[k][slot]) + SUM_W'(across[k]);
                        default:     line_sum[k][slot] = across[k];
                    endcase
                end
            end
            column++;
            if (column >= w) begin
                column = 0;
                row++;
                if (row >= h) begin
                    row = 0;
                end
            end
            if (hop != HOP_LEFT && vop != VOP_STORE) begin
                res.px.red   = block[0][SUM_W-1:2];
                res.px.green = block[1][SUM_W-1:2];
                res.px.blue  = block[2][SUM_W-1:2];
                res.last     = last;
                expected_q.push_back(res);
            end
        endfunction

        function void flag(string what, block_result_t want, block_result_t got);
            failures++;
            if (failures <= REPORT_LIMIT) begin
                $display("%0t: %s: expected r=%h g=%h b=%h end=%b, got r=%h g=%h b=%h end=%b",
                         $time, what, want.px.red, want.px.green, want.px.blue, want.last,
                         got.px.red, got.px.green, got.px.blue, got.last);
            end
        endfunction

        function void check_result(block_result_t got);
            block_result_t want;
            if (expected_q.size() == 0) begin
                flag("result with none expected", '0, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.px.red !== want.px.red || got.px.green !== want.px.green ||
                got.px.blue !== want.px.blue || got.last !== want.last) begin
                flag("wrong result", want, got);
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]  cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [CHAN_W-1:0] s_red_in = '0;
    logic [CHAN_W-1:0] s_green_in = '0;
    logic [CHAN_W-1:0] s_blue_in = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [CHAN_W-1:0] m_red_out;
    logic [CHAN_W-1:0] m_green_out;
    logic [CHAN_W-1:0] m_blue_out;
    logic              m_end_of_level;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_request = 1'b0;

    box_filter_scoreboard board = new;

    mipmap_box_downsample #(
        .MAX_WIDTH(MAX_WIDTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_red_in(s_red_in),
        .s_green_in(s_green_in),
        .s_blue_in(s_blue_in),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_red_out(m_red_out),
        .m_green_out(m_green_out),
        .m_blue_out(m_blue_out),
        .m_end_of_level(m_end_of_level)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            board.note_input(pixel_t'{s_red_in, s_green_in, s_blue_in});
        end
        if (aresetn && m_valid && m_ready) begin
            board.check_result(block_result_t'{pixel_t'{m_red_out, m_green_out, m_blue_out},
                                               m_end_of_level});
        end
    end

    initial begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [CHAN_W-1:0] random_channel();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        return pixel_t'{random_channel(), random_channel(), random_channel()};
    endfunction

    task automatic send_pixel(input pixel_t px);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_red_in   <= px.red;
        s_green_in <= px.green;
        s_blue_in  <= px.blue;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Holds the input back until every expected item has left and the pipeline is empty.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [IDX_W-1:0] index, input logic [CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= index;
        cfg_wr_data <= value;
        board.set_register(index, value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] wl, input logic [CFG_W-1:0] hl,
                             input logic [CFG_W-1:0] wm);
        settle();
        write_register(REG_WIDTH_LOG2, wl);
        write_register(REG_HEIGHT_LOG2, hl);
        write_register(REG_WRAP_MODE, wm);
    endtask

    initial begin : stimulus
        int unsigned      regime;
        int unsigned      sent;
        int unsigned      n;
        int unsigned      level;
        logic [CFG_W-1:0] wl;
        logic [CFG_W-1:0] hl;
        logic [CFG_W-1:0] wm;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset configuration: a single texel level under repeat.
        send_pixel(PIXEL_FULL);
        send_pixel(PIXEL_ZERO);
        configure(4'd0, 4'd0, WRAP_ZERO);
        send_pixel(PIXEL_FULL);
        configure(4'd0, 4'd0, WRAP_SPARE);
        send_pixel(pixel_t'{24'hAAAAAA, 24'h555555, 24'h000001});
        configure(4'd1, 4'd1, WRAP_CLAMP);
        send_pixel(PIXEL_FULL);
        send_pixel(PIXEL_FULL);
        send_pixel(PIXEL_FULL);
        send_pixel(pixel_t'{24'h000001, 24'h000003, 24'hFFFFFE});
        configure(4'd1, 4'd0, WRAP_ZERO);
        send_pixel(PIXEL_FULL);
        send_pixel(pixel_t'{24'h800000, 24'h000001, 24'hFFFFFF});
        configure(4'd0, 4'd1, WRAP_ZERO);
        send_pixel(pixel_t'{24'h123456, 24'hFFFFFF, 24'h000000});
        send_pixel(PIXEL_FULL);
        configure(4'd1, 4'd1, WRAP_REPEAT);
        send_pixel(PIXEL_FULL);
        send_pixel(pixel_t'{24'h000002, 24'h7FFFFF, 24'hC00000});
        settle();
        // A write to the spare index must leave the level where it stands.
        write_register(REG_UNUSED, '1);
        send_pixel(PIXEL_FULL);
        send_pixel(PIXEL_ZERO);

        for (regime = 0; regime < 3; regime++) begin
            send_idle_pct = (regime == 0) ? 9 : (regime == 1) ? 75 : 0;
            recv_idle_pct = (regime == 0) ? 75 : (regime == 1) ? 9 : 0;
            sent = 0;
            while (sent < REGIME_ITEMS) begin
                wl = CFG_W'($urandom_range(0, 4));
                hl = CFG_W'($urandom_range(0, 6 - wl));
                if (hl > 4'd4) begin
                    hl = 4'd4;
                end
                wm = CFG_W'($urandom_range(0, 3));
                configure(wl, hl, wm);
                level = (1 << wl) * (1 << hl);
                n = level * $urandom_range(1, 2) + $urandom_range(0, level);
                if (regime == 0 && sent == 0) begin
                    hold_request = 1'b1;
                    n += 40;
                end
                repeat (n) send_pixel(random_pixel());
                sent += n;
            end
        end

        // Oversized width and height saturate.
        configure(CFG_W'($urandom_range(13, 15)), 4'd0, CFG_W'($urandom_range(0, 3)));
        repeat (OVERSIZE_ITEMS) send_pixel(random_pixel());
        configure(4'd0, CFG_W'($urandom_range(12, 15)), CFG_W'($urandom_range(0, 3)));
        repeat (OVERSIZE_ITEMS) send_pixel(random_pixel());

        settle();
        if (board.pending() != 0) begin
            $display("%0d expected items never arrived", board.pending());
        end
        if (board.failures == 0 && board.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
